/* src/usd_pkg.sv */
// Package for the UTF-8 stream decoder: result codes, the result record and
// the queue sizing. Depends on nothing; used by every module of the block.
`default_nettype none

package usd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int APB_AW = 2;

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_END     = 2'd1,
        ST_INVALID = 2'd2,
        ST_PARTIAL = 2'd3
    } status_t;

    typedef struct packed {
        logic [30:0] code_point;
        status_t     status;
        logic [15:0] char_count;
        logic [15:0] bytes_read;
        logic        run_last;
    } usd_result_t;

    typedef struct packed {
        logic valid0;
        logic valid1;
    } usd_push_t;

    function automatic usd_result_t mk_result(input logic [30:0] cp, input status_t st,
                                              input logic [15:0] cc, input logic [15:0] br,
                                              input logic last);
        usd_result_t r;
        r.code_point = cp;
        r.status     = st;
        r.char_count = cc;
        r.bytes_read = br;
        r.run_last   = last;
        return r;
    endfunction

    function automatic logic [2:0] enc_len(input logic [30:0] v);
        logic [2:0] n;
        if (v < 31'h80)
            n = 3'd1;
        else if (v < 31'h800)
            n = 3'd2;
        else if (v < 31'h10000)
            n = 3'd3;
        else if (v < 31'h200000)
            n = 3'd4;
        else if (v < 31'h4000000)
            n = 3'd5;
        else
            n = 3'd6;
        return n;
    endfunction

endpackage

`default_nettype wire

/* src/usd_cfg.sv */
// APB-style configuration port holding the partial_allowed register.
// Depends on usd_pkg for the address width.
`default_nettype none

module usd_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [usd_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic                            partial_allowed
);
    import usd_pkg::*;

    logic partial_allowed_reg;
    logic partial_allowed_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        partial_allowed_next = partial_allowed_reg;
        if (wr_en && (paddr == '0)) begin
            partial_allowed_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_allowed_reg <= 1'b0;
        end else begin
            partial_allowed_reg <= partial_allowed_next;
        end
    end

    assign prdata          = {31'd0, partial_allowed_reg};
    assign partial_allowed = partial_allowed_reg;

endmodule

`default_nettype wire

/* src/usd_core.sv */
// Decoder state and the per-byte decode, producing up to two results a byte.
// Depends on usd_pkg for the result record and the status codes.
`default_nettype none

module usd_core #(
    parameter int COUNT_WIDTH = usd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          partial_allowed,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output usd_pkg::usd_push_t push,
    output usd_pkg::usd_result_t res0,
    output usd_pkg::usd_result_t res1
);
    import usd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [30:0]            acc_reg, acc_next;
    logic [2:0]             rem_reg, rem_next;
    logic [2:0]             seq_len_reg, seq_len_next;
    logic [COUNT_WIDTH-1:0] dc_reg, dc_next;
    logic [COUNT_WIDTH-1:0] bp_reg, bp_next;
    logic [COUNT_WIDTH-1:0] csp_reg, csp_next;
    logic                   discard_reg, discard_next;

    logic [COUNT_WIDTH-1:0] bp_inc;
    logic [COUNT_WIDTH-1:0] dc_inc;
    logic [30:0]            acc_shift;
    logic [2:0]             rem_dec;
    logic [2:0]             lead_len;
    logic [7:0]             lead_mask;
    status_t                partial_st;

    function automatic logic [15:0] to16(input logic [COUNT_WIDTH-1:0] x);
        logic [COUNT_WIDTH+15:0] e;
        e = {16'd0, x};
        return e[15:0];
    endfunction

    assign bp_inc     = (bp_reg == '1) ? bp_reg : bp_reg + CNT_ONE;
    assign dc_inc     = (dc_reg == '1) ? dc_reg : dc_reg + CNT_ONE;
    assign acc_shift  = {acc_reg[24:0], in_byte[5:0]};
    assign rem_dec    = rem_reg - 3'd1;
    assign partial_st = partial_allowed ? ST_END : ST_PARTIAL;

    always_comb begin
        if (in_byte[7:5] == 3'b110) begin
            lead_len  = 3'd2;
            lead_mask = 8'h1f;
        end else if (in_byte[7:4] == 4'b1110) begin
            lead_len  = 3'd3;
            lead_mask = 8'h0f;
        end else if (in_byte[7:3] == 5'b11110) begin
            lead_len  = 3'd4;
            lead_mask = 8'h07;
        end else if (in_byte[7:2] == 6'b111110) begin
            lead_len  = 3'd5;
            lead_mask = 8'h03;
        end else begin
            lead_len  = 3'd6;
            lead_mask = 8'h01;
        end
    end

    always_comb begin
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        seq_len_next = seq_len_reg;
        dc_next      = dc_reg;
        bp_next      = bp_reg;
        csp_next     = csp_reg;
        discard_next = discard_reg;
        push         = '0;
        res0         = mk_result(31'd0, ST_END, to16(dc_reg), to16(bp_reg), 1'b1);
        res1         = mk_result(31'd0, ST_END, to16(dc_inc), to16(bp_inc), 1'b1);

        if (in_valid) begin
            if (discard_reg) begin
                if (in_last) begin
                    discard_next = 1'b0;
                    acc_next = '0; rem_next = '0; seq_len_next = '0;
                    dc_next = '0; bp_next = '0; csp_next = '0;
                end
            end else if (rem_reg == 3'd0) begin
                if (in_byte == 8'h00) begin
                    push.valid0  = 1'b1;
                    discard_next = !in_last;
                end else if (!in_byte[7]) begin
                    push.valid0 = 1'b1;
                    res0 = mk_result({23'd0, in_byte}, ST_CHAR, to16(dc_inc), to16(bp_inc),
                                     1'b0);
                    bp_next = bp_inc;
                    dc_next = dc_inc;
                    if (in_last) begin
                        push.valid1 = 1'b1;
                    end
                end else if ((in_byte[7:6] == 2'b10) || (in_byte[7:1] == 7'b1111111)) begin
                    push.valid0  = 1'b1;
                    res0.status  = ST_INVALID;
                    discard_next = !in_last;
                end else begin
                    csp_next     = bp_reg;
                    bp_next      = bp_inc;
                    acc_next     = {23'd0, in_byte & lead_mask};
                    seq_len_next = lead_len;
                    rem_next     = lead_len - 3'd1;
                    if (in_last) begin
                        push.valid0 = 1'b1;
                        res0.status = partial_st;
                    end
                end
                if (in_last && !discard_reg) begin
                    acc_next = '0; rem_next = '0; seq_len_next = '0;
                    dc_next = '0; bp_next = '0; csp_next = '0;
                end
            end else if (in_byte[7:6] == 2'b10) begin
                acc_next = acc_shift;
                bp_next  = bp_inc;
                rem_next = rem_dec;
                if (rem_dec != 3'd0) begin
                    if (in_last) begin
                        push.valid0 = 1'b1;
                        res0 = mk_result(31'd0, partial_st, to16(dc_reg), to16(csp_reg), 1'b1);
                    end
                end else if (enc_len(acc_shift) != seq_len_reg) begin
                    push.valid0  = 1'b1;
                    res0 = mk_result(31'd0, ST_INVALID, to16(dc_reg), to16(csp_reg), 1'b1);
                    discard_next = !in_last;
                end else begin
                    push.valid0  = 1'b1;
                    res0 = mk_result(acc_shift, ST_CHAR, to16(dc_inc), to16(bp_inc), 1'b0);
                    dc_next      = dc_inc;
                    acc_next     = '0;
                    seq_len_next = '0;
                    push.valid1  = in_last;
                end
                if (in_last) begin
                    acc_next = '0; rem_next = '0; seq_len_next = '0;
                    dc_next = '0; bp_next = '0; csp_next = '0;
                end
            end else begin
                push.valid0  = 1'b1;
                res0 = mk_result(31'd0, (in_byte == 8'h00) ? partial_st : ST_INVALID,
                                 to16(dc_reg), to16(csp_reg), 1'b1);
                discard_next = !in_last;
                if (in_last) begin
                    acc_next = '0; rem_next = '0; seq_len_next = '0;
                    dc_next = '0; bp_next = '0; csp_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            rem_reg     <= '0;
            seq_len_reg <= '0;
            dc_reg      <= '0;
            bp_reg      <= '0;
            csp_reg     <= '0;
            discard_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            seq_len_reg <= seq_len_next;
            dc_reg      <= dc_next;
            bp_reg      <= bp_next;
            csp_reg     <= csp_next;
            discard_reg <= discard_next;
        end
    end

`ifndef SYNTH
    a_two_results_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid1 |-> (push.valid0 && (res0.status == ST_CHAR) && res1.run_last))
        else $error("second result without a character before it");

    a_no_result_discarding: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && discard_reg) |-> !push.valid0)
        else $error("result produced while dropping bytes");

    a_final_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid0 && (res0.status != ST_CHAR)) |-> res0.run_last)
        else $error("status result not marked final");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_last) |=> ((rem_reg == 3'd0) && !discard_reg && (bp_reg == '0)
                                   && (dc_reg == '0)))
        else $error("string state not cleared after the last byte");
`endif

endmodule

`default_nettype wire

/* src/usd_fifo.sv */
// Result queue taking up to two results a cycle and giving one a cycle while out_ready is high.
// Depends on usd_pkg for the result record and the queue depth.
`default_nettype none

module usd_fifo (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire usd_pkg::usd_push_t        push,
    input  wire usd_pkg::usd_result_t      res0,
    input  wire usd_pkg::usd_result_t      res1,
    output logic [usd_pkg::FIFO_AW:0]      level,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output usd_pkg::usd_result_t           out_data
);
    import usd_pkg::*;

    usd_result_t        mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic [FIFO_AW-1:0] wptr_inc;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rptr_reg];
    assign level     = count_reg;
    assign wptr_inc  = wptr_reg + {{(FIFO_AW-1){1'b0}}, 1'b1};

    always_comb begin
        wptr_next  = wptr_reg + {{(FIFO_AW-1){1'b0}}, push.valid0}
                              + {{(FIFO_AW-1){1'b0}}, push.valid1};
        rptr_next  = rptr_reg + {{(FIFO_AW-1){1'b0}}, pop};
        count_next = count_reg + {{FIFO_AW{1'b0}}, push.valid0}
                               + {{FIFO_AW{1'b0}}, push.valid1}
                               - {{FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            mem[wptr_reg] <= res0;
        end
        if (push.valid1) begin
            mem[wptr_inc] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* src/utf8_stream_decoder_unit.sv */
// Top level of the validating UTF-8 stream decoder.
// Depends on usd_pkg, usd_cfg, usd_core and usd_fifo.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   s_data_byte, s_end_of_input
//   m_       out        m_valid / m_ready   m_code_point, m_status, m_char_count,
//                                           m_bytes_read, m_run_last
//   apb      in         psel / penable      paddr, pwdata, prdata (partial_allowed)
//
// One byte is taken per cycle into the input register while s_ready is high, and is decoded
// in the next cycle. Its results enter the queue at the following edge, which raises m_valid,
// and the first result can then be taken from the queue.
// A last byte that completes a character yields two results, which are read out one at
// a time; an eight-entry result queue absorbs them.
// s_ready drops when the queued results, plus two for a byte in the input register,
// would leave no room for two more.
// Reset is synchronous and needs no clearing pass.
`default_nettype none

module utf8_stream_decoder_unit #(
    parameter int COUNT_WIDTH = usd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_data_byte,
    input  wire logic                       s_end_of_input,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [30:0]                     m_code_point,
    output logic [1:0]                      m_status,
    output logic [15:0]                     m_char_count,
    output logic [15:0]                     m_bytes_read,
    output logic                            m_run_last,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [usd_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import usd_pkg::*;

    localparam logic [FIFO_AW+1:0] READY_LIMIT = (FIFO_AW+2)'(FIFO_DEPTH - 2);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             partial_allowed;
    usd_push_t        push;
    usd_result_t      res0;
    usd_result_t      res1;
    usd_result_t      out_data;
    logic [FIFO_AW:0] level;
    logic [FIFO_AW+1:0] reserved;

    assign reserved      = {1'b0, level} + (in_valid_reg ? (FIFO_AW+2)'(2) : '0);
    assign s_ready       = (reserved <= READY_LIMIT);
    assign in_valid_next = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_next) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_end_of_input;
        end
    end

    usd_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .partial_allowed (partial_allowed)
    );

    usd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .partial_allowed (partial_allowed),
        .in_valid        (in_valid_reg),
        .in_byte         (in_byte_reg),
        .in_last         (in_last_reg),
        .push            (push),
        .res0            (res0),
        .res1            (res1)
    );

    usd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .res0      (res0),
        .res1      (res1),
        .level     (level),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_code_point = out_data.code_point;
    assign m_status     = out_data.status;
    assign m_char_count = out_data.char_count;
    assign m_bytes_read = out_data.bytes_read;
    assign m_run_last   = out_data.run_last;

endmodule

`default_nettype wire
